@@ hdl/rtwv_pkg.sv @@
package rtwv_pkg;

  // Field widths fixed by the item format
  localparam int KIND_W   = 2;
  localparam int SYMBOL_W = 6;
  localparam int WINDOW_W = 9;
  localparam int ID_W     = 64;

  // Reachable symbols with a SYMBOL_W-bit index
  localparam int MAX_SYM = 1 << SYMBOL_W;

  // Default sizing of the per-symbol rings
  localparam int DEF_SYMBOLS = 64;
  localparam int DEF_DEPTH   = 256;

  // Entries in the queue between the front and the back
  localparam int QUEUE_DEPTH = 2;

  // Item kinds as they arrive on the input channel
  typedef enum logic [KIND_W-1:0] {
    KIND_RECORD = 2'd0,
    KIND_PAIR   = 2'd1,
    KIND_HASH   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  // One classified beat handed from the front to the back
  typedef struct packed {
    kind_e               kind;
    logic                oor;
    logic [SYMBOL_W-1:0] sym;
    logic [ID_W-1:0]     ask;
    logic [ID_W-1:0]     bid;
    logic [ID_W-1:0]     hash;
  } item_t;

endpackage

@@ hdl/rtwv_front.sv @@
module rtwv_front #(
  parameter int SYMBOLS = rtwv_pkg::DEF_SYMBOLS
) (
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic        [rtwv_pkg::KIND_W-1:0]   kind_i,
  input  logic        [rtwv_pkg::SYMBOL_W-1:0] symbol_index_i,
  input  logic signed [rtwv_pkg::ID_W-1:0]     ask_id_i,
  input  logic signed [rtwv_pkg::ID_W-1:0]     bid_id_i,
  input  logic        [rtwv_pkg::ID_W-1:0]     tick_hash_i,
  input  logic                                enq_full_i,
  output logic                                enq_valid_o,
  output rtwv_pkg::item_t                     enq_item_o
);
  import rtwv_pkg::*;

  kind_e kind;
  logic  oor;
  logic  keep;

  // Classify the beat: symbols past the table are never seen
  assign kind = kind_e'(kind_i);
  assign oor  = 32'(symbol_index_i) >= 32'(SYMBOLS);

  // Drop unused kinds and records for symbols past the table
  always_comb begin
    case (kind)
      KIND_RECORD: keep = !oor;
      KIND_PAIR,
      KIND_HASH:   keep = 1'b1;
      default:     keep = 1'b0;
    endcase
  end

  // Hold the input while the queue is full
  assign in_stall_o  = enq_full_i;
  assign enq_valid_o = in_valid_i && !enq_full_i && keep;

  assign enq_item_o.kind = kind;
  assign enq_item_o.oor  = oor;
  assign enq_item_o.sym  = symbol_index_i;
  assign enq_item_o.ask  = unsigned'(ask_id_i);
  assign enq_item_o.bid  = unsigned'(bid_id_i);
  assign enq_item_o.hash = tick_hash_i;

endmodule

@@ hdl/rtwv_fifo.sv @@
module rtwv_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            enq_valid_i,
  input  rtwv_pkg::item_t enq_item_i,
  output logic            full_o,
  output logic            deq_valid_o,
  output rtwv_pkg::item_t deq_item_o,
  input  logic            deq_pop_i
);
  import rtwv_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               push, pop;

  assign full_o      = count_q == CNT_W'(QUEUE_DEPTH);
  assign deq_valid_o = count_q != '0;
  assign deq_item_o  = slot_q[rd_ptr_q];

  assign push = enq_valid_i && !full_o;
  assign pop  = deq_pop_i && deq_valid_o;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= enq_item_i;
    end
  end

endmodule

@@ hdl/rtwv_back.sv @@
module rtwv_back #(
  parameter int SYMBOLS = rtwv_pkg::DEF_SYMBOLS,
  parameter int DEPTH   = rtwv_pkg::DEF_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rtwv_pkg::WINDOW_W-1:0]   cfg_wdata_i,
  input  logic                            deq_valid_i,
  input  rtwv_pkg::item_t                 deq_item_i,
  output logic                            deq_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            is_valid_o,
  output logic                            answered_kind_o
);
  import rtwv_pkg::*;

  localparam int NSYM    = (SYMBOLS < MAX_SYM) ? SYMBOLS : MAX_SYM;
  localparam int SYM_W   = (NSYM > 1) ? $clog2(NSYM) : 1;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int META_W  = CNT_W + IDX_W;
  localparam int ENTRIES = NSYM * DEPTH;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RING_W  = 3 * ID_W;
  localparam int WIN_RST = (DEPTH < (1 << WINDOW_W)) ? DEPTH : (1 << WINDOW_W) - 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_META,
    S_SCAN,
    S_RESULT
  } state_e;

  state_e              state_q;
  logic [WINDOW_W-1:0] win_q;
  logic [NSYM-1:0]     seen_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [CNT_W-1:0]    len_q;
  logic                pend_q;
  logic                hit_a_q;
  logic                hit_b_q;
  logic                out_valid_q;
  logic                is_valid_q;
  logic                answered_kind_q;

  item_t               cur_q;
  logic [ADDR_W-1:0]   base_q;

  logic [META_W-1:0]   meta_mem [NSYM];
  logic [META_W-1:0]   meta_rd_q;
  logic [RING_W-1:0]   ring_mem [ENTRIES];
  logic [RING_W-1:0]   ring_rd_q;

  logic [SYM_W-1:0]    deq_idx;
  logic [SYM_W-1:0]    cur_idx;
  logic [CNT_W-1:0]    win_eff;
  logic [CNT_W-1:0]    fill_rd;
  logic [IDX_W-1:0]    head_rd;
  logic                seen_cur;
  logic [CNT_W-1:0]    fill_eff;
  logic [IDX_W-1:0]    head_eff;
  logic [CNT_W-1:0]    len_eff;
  logic [IDX_W-1:0]    slot;
  logic [CNT_W-1:0]    slot_inc;
  logic [CNT_W-1:0]    new_fill;
  logic [IDX_W-1:0]    new_head;
  logic                rec_we;
  logic                ring_re;
  logic [ADDR_W-1:0]   ring_waddr;
  logic [ADDR_W-1:0]   ring_raddr;
  logic                hit_a;
  logic                hit_b;
  logic                out_free;

  assign deq_idx = deq_item_i.sym[SYM_W-1:0];
  assign cur_idx = cur_q.sym[SYM_W-1:0];

  // Clamp the window to 1..DEPTH
  always_comb begin
    if (win_q == '0) begin
      win_eff = CNT_W'(1);
    end else if (32'(win_q) > DEPTH) begin
      win_eff = CNT_W'(DEPTH);
    end else begin
      win_eff = CNT_W'(win_q);
    end
  end

  // Unseen symbols read as an empty ring
  assign fill_rd  = meta_rd_q[META_W-1:IDX_W];
  assign head_rd  = meta_rd_q[IDX_W-1:0];
  assign seen_cur = !cur_q.oor && seen_q[cur_idx];
  assign fill_eff = seen_cur ? fill_rd : '0;
  assign head_eff = seen_cur ? head_rd : '0;
  assign len_eff  = (fill_eff < win_eff) ? fill_eff : win_eff;

  // Pick the slot to write: append while filling, else overwrite at the head
  always_comb begin
    if (fill_eff < win_eff) begin
      slot     = IDX_W'(fill_eff);
      new_fill = fill_eff + CNT_W'(1);
      new_head = '0;
      slot_inc = '0;
    end else begin
      slot     = (CNT_W'(head_eff) >= win_eff) ? '0 : head_eff;
      new_fill = win_eff;
      slot_inc = CNT_W'(slot) + CNT_W'(1);
      new_head = (slot_inc >= win_eff) ? '0 : IDX_W'(slot_inc);
    end
  end

  assign rec_we     = (state_q == S_META) && (cur_q.kind == KIND_RECORD);
  assign ring_waddr = base_q + ADDR_W'(slot);
  assign ring_re    = (state_q == S_SCAN) && (cnt_q < len_q);
  assign ring_raddr = base_q + ADDR_W'(cnt_q);

  // Compare the entry read in the previous cycle
  always_comb begin
    if (cur_q.kind == KIND_HASH) begin
      hit_a = ring_rd_q[ID_W-1:0] == cur_q.hash;
      hit_b = 1'b1;
    end else begin
      hit_a = ring_rd_q[RING_W-1:2*ID_W] == cur_q.ask;
      hit_b = ring_rd_q[2*ID_W-1:ID_W] == cur_q.bid;
    end
  end

  assign deq_pop_o = (state_q == S_IDLE) && deq_valid_i;
  assign out_free  = !out_valid_q || !out_stall_i;

  // Sequence one beat: fetch ring state, store a record or scan and answer a check
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      win_q           <= WINDOW_W'(WIN_RST);
      seen_q          <= '0;
      cnt_q           <= '0;
      len_q           <= '0;
      pend_q          <= 1'b0;
      hit_a_q         <= 1'b0;
      hit_b_q         <= 1'b0;
      out_valid_q     <= 1'b0;
      is_valid_q      <= 1'b0;
      answered_kind_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      // Load a new answer or retire the accepted one
      if ((state_q == S_RESULT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (deq_valid_i) begin
            state_q <= S_META;
          end
        end
        S_META: begin
          if (cur_q.kind == KIND_RECORD) begin
            seen_q[cur_idx] <= 1'b1;
            state_q         <= S_IDLE;
          end else begin
            hit_a_q <= !seen_cur;
            hit_b_q <= !seen_cur;
            len_q   <= len_eff;
            cnt_q   <= '0;
            pend_q  <= 1'b0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend_q <= ring_re;
          if (ring_re) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
          if (pend_q) begin
            hit_a_q <= hit_a_q | hit_a;
            hit_b_q <= hit_b_q | hit_b;
          end
          if (!ring_re && !pend_q) begin
            state_q <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            is_valid_q      <= (cur_q.kind == KIND_HASH) ? hit_a_q : (hit_a_q && hit_b_q);
            answered_kind_q <= cur_q.kind == KIND_HASH;
            state_q         <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Latch the popped beat and its ring base address
  always_ff @(posedge clk_i) begin
    if (deq_pop_o) begin
      cur_q  <= deq_item_i;
      base_q <= ADDR_W'(deq_idx) * ADDR_W'(DEPTH);
    end
  end

  // Per-symbol fill and head
  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      meta_mem[cur_idx] <= {new_fill, new_head};
    end
    if (deq_pop_o) begin
      meta_rd_q <= meta_mem[deq_idx];
    end
  end

  // Ask, bid and hash rings side by side in one entry
  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      ring_mem[ring_waddr] <= {cur_q.ask, cur_q.bid, cur_q.hash};
    end
    if (ring_re) begin
      ring_rd_q <= ring_mem[ring_raddr];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_valid_o      = is_valid_q;
  assign answered_kind_o = answered_kind_q;

endmodule

@@ hdl/recent_tick_window_validator.sv @@
// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_stall_o   kind_i, symbol_index_i, ask_id_i,
//                                             bid_id_i, tick_hash_i
// output    out        out_valid_o/out_stall_i is_valid_o, answered_kind_o
// config    in         cfg_we_i                cfg_wdata_i (window size)
//
// A record passes the back's idle and meta states; a check passes idle, meta, scan
// and result. The scan reads n = min(ring fill, window) entries, none for an unseen
// symbol, one entry per cycle through the single read port of the ring memory, and
// the result waits for a stalled answer to drain from the output register.
// Reset clears seen flags, window to min(DEPTH, 511); ring memories are not cleared.
// A two-beat queue decouples input from the back, and the output register
// lets the back start the next beat while an answer is still stalled.
module recent_tick_window_validator #(
  parameter int SYMBOLS = rtwv_pkg::DEF_SYMBOLS,
  parameter int DEPTH   = rtwv_pkg::DEF_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic        [rtwv_pkg::WINDOW_W-1:0] cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic        [rtwv_pkg::KIND_W-1:0]   kind_i,
  input  logic        [rtwv_pkg::SYMBOL_W-1:0] symbol_index_i,
  input  logic signed [rtwv_pkg::ID_W-1:0]     ask_id_i,
  input  logic signed [rtwv_pkg::ID_W-1:0]     bid_id_i,
  input  logic        [rtwv_pkg::ID_W-1:0]     tick_hash_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                is_valid_o,
  output logic                                answered_kind_o
);
  import rtwv_pkg::*;

  logic  enq_valid;
  logic  enq_full;
  item_t enq_item;
  logic  deq_valid;
  logic  deq_pop;
  item_t deq_item;

  // Accept and classify beats
  rtwv_front #(
    .SYMBOLS (SYMBOLS)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .symbol_index_i (symbol_index_i),
    .ask_id_i       (ask_id_i),
    .bid_id_i       (bid_id_i),
    .tick_hash_i    (tick_hash_i),
    .enq_full_i     (enq_full),
    .enq_valid_o    (enq_valid),
    .enq_item_o     (enq_item)
  );

  // Buffer classified beats
  rtwv_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enq_valid_i (enq_valid),
    .enq_item_i  (enq_item),
    .full_o      (enq_full),
    .deq_valid_o (deq_valid),
    .deq_item_o  (deq_item),
    .deq_pop_i   (deq_pop)
  );

  // Update rings and answer checks
  rtwv_back #(
    .SYMBOLS (SYMBOLS),
    .DEPTH   (DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .deq_valid_i     (deq_valid),
    .deq_item_i      (deq_item),
    .deq_pop_o       (deq_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .is_valid_o      (is_valid_o),
    .answered_kind_o (answered_kind_o)
  );

endmodule
